### hw/rtl/rxp_pkg.sv
`default_nettype none

package rxp_pkg;

   // Special characters of the regex syntax
   localparam logic [7:0] CH_UNION  = 8'd124;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_PLUS   = 8'd43;
   localparam logic [7:0] CH_OPEN   = 8'd40;
   localparam logic [7:0] CH_CLOSE  = 8'd41;
   localparam logic [7:0] CH_BSLASH = 8'd92;

   localparam logic [7:0] CONCAT_RESET = 8'd46;

   typedef logic [1:0] prec_type;

   localparam prec_type PREC_NONE   = 2'd0;
   localparam prec_type PREC_UNION  = 2'd1;
   localparam prec_type PREC_CONCAT = 2'd2;
   localparam prec_type PREC_REPEAT = 2'd3;

   // Operator precedence; union is tested ahead of the concat character
   function automatic prec_type prec_of(input logic [7:0] c, input logic [7:0] concat);
      prec_type p;
      if (c == CH_UNION) begin
         p = PREC_UNION;
      end else if (c == concat) begin
         p = PREC_CONCAT;
      end else if (c == CH_STAR || c == CH_PLUS) begin
         p = PREC_REPEAT;
      end else begin
         p = PREC_NONE;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rxp_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// Read data holds while no read is issued.
module rxp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/regex_infix_to_postfix.sv
`default_nettype none

// Streaming shunting-yard converter from an infix regex (explicit concat operators,
// ranges already expanded) to postfix, one byte in per item, zero or more bytes out.
// Operators wait on a stack held in a small RAM; the concat character is set by
// csr_wr_en/csr_wr_data, which the user must write only while the block is idle (the
// block itself does not enforce this). An escaped byte comes out followed by a
// backslash marker. The final byte of an expression flushes the stack; its last
// result carries rsp_out_end, and if it produced nothing a bare end marker
// (rsp_has_char = 0) is sent. Timing: one byte is taken at a time, and the block is
// not ready again until the byte's results have reached the output register. Each
// stack entry examined, whether popped, compared or dropped, is read through the
// RAM's registered read port, and the precedence check uses its data in the
// following cycle; a result waiting on rsp_ready stalls the sequencer. A full
// stack drops the push and sets rsp_overflow on all results until the end of the
// expression. Each result passes through a one-deep holding register so the end
// flag lands on the true final result; all results of an item reach the output
// register before the next is taken.
module regex_infix_to_postfix #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   // input items
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_in_last,
   // result items
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_out_char,
   output logic            rsp_has_char,
   output logic            rsp_out_end,
   output logic            rsp_overflow
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ESC1    = 3'd1;
   localparam logic [2:0] S_ESC2    = 3'd2;
   localparam logic [2:0] S_LIT     = 3'd3;
   localparam logic [2:0] S_POP_RD  = 3'd4;
   localparam logic [2:0] S_POP_CHK = 3'd5;
   localparam logic [2:0] S_PUSH    = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   // pop loop modes
   localparam logic [1:0] M_FLUSH = 2'd0;
   localparam logic [1:0] M_CLOSE = 2'd1;
   localparam logic [1:0] M_OP    = 2'd2;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;
   rxp_pkg::prec_type    prec_ff, prec_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 esc_ff, esc_in;
   logic                 overflow_ff, overflow_in;
   logic [7:0]           concat_ff, concat_in;
   logic                 hold_v_ff, hold_v_in;
   logic [7:0]           hold_char_ff, hold_char_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 ram_we;
   logic                 ram_re;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   logic [7:0]           ram_rdata;
   logic [CW-1:0]        count_dec;

   logic                 out_free;
   logic                 can_emit;
   logic                 emit_req;
   logic [7:0]           emit_char;
   logic                 is_op;
   logic [7:0]           prec_src;
   rxp_pkg::prec_type    prec_val;

   // operator stack storage
   rxp_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (char_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign count_dec = count_ff - CW'(1);
   assign ram_raddr = count_dec[AW-1:0];
   assign ram_waddr = count_ff[AW-1:0];

   // shared precedence unit: incoming byte when idle, stack top otherwise
   assign prec_src = (state_ff == S_IDLE) ? req_in_char : ram_rdata;
   assign prec_val = rxp_pkg::prec_of(prec_src, concat_ff);

   assign is_op = (req_in_char == rxp_pkg::CH_STAR) || (req_in_char == rxp_pkg::CH_PLUS) ||
                  (req_in_char == rxp_pkg::CH_UNION) || (req_in_char == concat_ff);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_emit = !hold_v_ff || out_free;

   // sequencer and result path
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      prec_in      = prec_ff;
      count_in     = count_ff;
      esc_in       = esc_ff;
      overflow_in  = overflow_ff;
      concat_in    = csr_wr_en ? csr_wr_data : concat_ff;
      hold_v_in    = hold_v_ff;
      hold_char_in = hold_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      emit_req     = 1'b0;
      emit_char    = char_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in = req_in_char;
               last_in = req_in_last;
               mode_in = M_FLUSH;
               if (esc_ff) begin
                  esc_in   = 1'b0;
                  state_in = S_ESC1;
               end else if (req_in_char == rxp_pkg::CH_BSLASH) begin
                  // a trailing lone backslash only flushes
                  esc_in   = !req_in_last;
                  state_in = S_POP_RD;
               end else if (req_in_char == rxp_pkg::CH_OPEN) begin
                  state_in = S_PUSH;
               end else if (req_in_char == rxp_pkg::CH_CLOSE) begin
                  mode_in  = M_CLOSE;
                  state_in = S_POP_RD;
               end else if (is_op) begin
                  mode_in  = M_OP;
                  prec_in  = prec_val;
                  state_in = S_POP_RD;
               end else begin
                  state_in = S_LIT;
               end
            end
         end
         S_ESC1: begin
            emit_req = 1'b1;
            if (can_emit) begin
               state_in = S_ESC2;
            end
         end
         S_ESC2: begin
            emit_req  = 1'b1;
            emit_char = rxp_pkg::CH_BSLASH;
            if (can_emit) begin
               state_in = S_POP_RD;
            end
         end
         S_LIT: begin
            emit_req = 1'b1;
            if (can_emit) begin
               state_in = S_POP_RD;
            end
         end
         S_POP_RD: begin
            if (count_ff == '0) begin
               if (mode_ff == M_CLOSE) begin
                  mode_in = M_FLUSH;
               end else if (mode_ff == M_OP) begin
                  state_in = S_PUSH;
               end else begin
                  state_in = S_DONE;
               end
            end else if (mode_ff == M_FLUSH && !last_ff) begin
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_POP_CHK;
            end
         end
         S_POP_CHK: begin
            emit_char = ram_rdata;
            if (mode_ff == M_CLOSE && ram_rdata == rxp_pkg::CH_OPEN) begin
               // matching open parenthesis is dropped
               count_in = count_dec;
               mode_in  = M_FLUSH;
               state_in = S_POP_RD;
            end else if (mode_ff == M_OP && prec_val < prec_ff) begin
               state_in = S_PUSH;
            end else begin
               emit_req = 1'b1;
               if (can_emit) begin
                  count_in = count_dec;
                  state_in = S_POP_RD;
               end
            end
         end
         S_PUSH: begin
            if (count_ff < CW'(STACK_DEPTH)) begin
               ram_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end else begin
               overflow_in = 1'b1;
            end
            mode_in  = M_FLUSH;
            state_in = S_POP_RD;
         end
         S_DONE: begin
            if (hold_v_ff || last_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = hold_v_ff ? hold_char_ff : 8'd0;
                  rsp_has_in   = hold_v_ff;
                  rsp_end_in   = last_ff;
                  rsp_ovf_in   = overflow_ff;
                  hold_v_in    = 1'b0;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
            // expression state returns to zero after the final byte
            if (last_ff && (out_free || !(hold_v_ff || last_ff))) begin
               count_in    = '0;
               esc_in      = 1'b0;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // new result goes to the holding register, pushing the previous one out
      if (emit_req && can_emit) begin
         if (hold_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = hold_char_ff;
            rsp_has_in   = 1'b1;
            rsp_end_in   = 1'b0;
            rsp_ovf_in   = overflow_ff;
         end
         hold_v_in    = 1'b1;
         hold_char_in = emit_char;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         esc_ff       <= 1'b0;
         overflow_ff  <= 1'b0;
         concat_ff    <= rxp_pkg::CONCAT_RESET;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         esc_ff       <= esc_in;
         overflow_ff  <= overflow_in;
         concat_ff    <= concat_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      prec_ff      <= prec_in;
      hold_char_ff <= hold_char_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_has_char = rsp_has_ff;
   assign rsp_out_end  = rsp_end_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // holding register is drained before the next item is taken
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_v_ff)
      else $error("result held while idle");

   // stack count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count out of range");

   // end of expression clears the expression state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && state_in == S_IDLE && last_ff)
      |=> (count_ff == '0 && !esc_ff && !overflow_ff))
      else $error("expression state not cleared at end");

   // a bare marker only closes an expression
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_end_ff)
      else $error("bare marker without end flag");

endmodule

`default_nettype wire

### sim/tb_regex_infix_to_postfix.sv
`default_nettype none

module tb_regex_infix_to_postfix;

   localparam int OP_DEPTH     = 32;
   localparam int PHASE_ITEMS  = 20;
   localparam int PAUSE_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int NUM_PHASES   = 8;

   // one postfix byte as seen on the result channel
   typedef struct packed {
      logic [7:0] ch;
      logic       has;
      logic       fin;
      logic       ovf;
   } postfix_byte_type;

   // Shunting-yard predictor plus the queue of postfix bytes still owed by the block
   class postfix_scoreboard;
      logic [7:0]       op_stack [OP_DEPTH];
      int               depth_used;
      bit               esc_open;
      bit               ovf_flag;
      logic [7:0]       concat;
      postfix_byte_type batch[$];
      postfix_byte_type expected_q[$];
      int               errors;

      function new();
         depth_used = 0;
         esc_open   = 0;
         ovf_flag   = 0;
         concat     = rxp_pkg::CONCAT_RESET;
         errors     = 0;
      endfunction

      // union is tested ahead of the concat character
      function rxp_pkg::prec_type rank(logic [7:0] c);
         if (c == rxp_pkg::CH_UNION) return rxp_pkg::PREC_UNION;
         if (c == concat) return rxp_pkg::PREC_CONCAT;
         if (c == rxp_pkg::CH_STAR || c == rxp_pkg::CH_PLUS) return rxp_pkg::PREC_REPEAT;
         return rxp_pkg::PREC_NONE;
      endfunction

      function void emit(logic [7:0] c, logic has);
         postfix_byte_type b;
         b.ch  = c;
         b.has = has;
         b.fin = 1'b0;
         b.ovf = 1'b0;
         batch = {batch, b};
      endfunction

      function void push_op(logic [7:0] c);
         if (depth_used < OP_DEPTH) begin
            op_stack[depth_used] = c;
            depth_used++;
         end else begin
            ovf_flag = 1;
         end
      endfunction

      function logic [7:0] pop_op();
         depth_used--;
         return op_stack[depth_used];
      endfunction

      // accepted input item: work out the postfix bytes it releases
      function void note_item(logic [7:0] c, logic last);
         rxp_pkg::prec_type p;
         postfix_byte_type  b;
         int                n;
         batch = {};
         if (esc_open) begin
            esc_open = 0;
            emit(c, 1'b1);
            emit(rxp_pkg::CH_BSLASH, 1'b1);
         end else if (c == rxp_pkg::CH_BSLASH) begin
            if (!last) esc_open = 1;
         end else if (c == rxp_pkg::CH_OPEN) begin
            push_op(c);
         end else if (c == rxp_pkg::CH_CLOSE) begin
            // pop to the matching open; an unmatched close drains everything
            while (depth_used > 0 && op_stack[depth_used - 1] != rxp_pkg::CH_OPEN)
               emit(pop_op(), 1'b1);
            if (depth_used > 0) depth_used--;
         end else if (c == rxp_pkg::CH_STAR || c == rxp_pkg::CH_PLUS ||
                      c == rxp_pkg::CH_UNION || c == concat) begin
            p = rank(c);
            while (depth_used > 0 && rank(op_stack[depth_used - 1]) >= p)
               emit(pop_op(), 1'b1);
            push_op(c);
         end else begin
            emit(c, 1'b1);
         end

         // end of expression: flush, bare end marker when nothing came out
         if (last) begin
            while (depth_used > 0) emit(pop_op(), 1'b1);
            if (batch.size() == 0) emit(8'd0, 1'b0);
         end

         n = batch.size();
         for (int i = 0; i < n; i++) begin
            b = batch[i];
            b.fin = last && (i == n - 1);
            b.ovf = ovf_flag;
            expected_q = {expected_q, b};
         end

         if (last) begin
            depth_used = 0;
            esc_open   = 0;
            ovf_flag   = 0;
         end
      endfunction

      function string show(postfix_byte_type b);
         return $sformatf("char %0d has %0b end %0b ovf %0b", b.ch, b.has, b.fin, b.ovf);
      endfunction

      function void check_result(postfix_byte_type got);
         postfix_byte_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: expected none, actual %s", $time, show(got));
            return;
         end
         want = expected_q.pop_front();
         if (want !== got) begin
            errors++;
            $display("%0t: mismatch: expected %s, actual %s", $time, show(want), show(got));
         end
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'd0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_has_char;
   logic       rsp_out_end;
   logic       rsp_overflow;

   postfix_scoreboard sb = new();

   bit         idle_on    = 1'b1;
   int         stall_left = 0;
   int         cycle_count = 0;
   logic [7:0] cur_concat = rxp_pkg::CONCAT_RESET;
   logic [7:0] byte_q[$];

   regex_infix_to_postfix #(.STACK_DEPTH(OP_DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_char  (req_in_char),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_has_char (rsp_has_char),
      .rsp_out_end  (rsp_out_end),
      .rsp_overflow (rsp_overflow)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_regex_infix_to_postfix: done, errors");
         $finish;
      end
   end

   // result side: check accepted items, stall in short random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_out_char, rsp_has_char, rsp_out_end, rsp_overflow});
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // append one byte to the expression being built
   function automatic void put_byte(input logic [7:0] c);
      byte_q = {byte_q, c};
   endfunction

   // literal byte that is not special under the current concat character
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == rxp_pkg::CH_UNION || c == rxp_pkg::CH_STAR || c == rxp_pkg::CH_PLUS ||
                 c == rxp_pkg::CH_OPEN || c == rxp_pkg::CH_CLOSE ||
                 c == rxp_pkg::CH_BSLASH || c == cur_concat);
      return c;
   endfunction

   // well-formed regex generator: alt := cat ('|' cat)*, cat := factor (concat factor)*
   function automatic void gen_factor(int depth);
      int pick;
      pick = $urandom_range(0, 9);
      if (depth > 0 && pick < 3) begin
         put_byte(rxp_pkg::CH_OPEN);
         gen_alt(depth - 1);
         put_byte(rxp_pkg::CH_CLOSE);
      end else if (pick == 3) begin
         put_byte(rxp_pkg::CH_BSLASH);
         put_byte(8'($urandom_range(0, 255)));
      end else begin
         put_byte(plain_byte());
      end
      case ($urandom_range(0, 5))
         0: put_byte(rxp_pkg::CH_STAR);
         1: put_byte(rxp_pkg::CH_PLUS);
         2: begin
            put_byte(rxp_pkg::CH_STAR);
            put_byte(rxp_pkg::CH_PLUS);
         end
         default: ;
      endcase
   endfunction

   function automatic void gen_cat(int depth);
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         if (i > 0) put_byte(cur_concat);
         gen_factor(depth);
      end
   endfunction

   function automatic void gen_alt(int depth);
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         if (i > 0) put_byte(rxp_pkg::CH_UNION);
         gen_cat(depth);
      end
   endfunction

   // short run of mostly special bytes, possibly ending in a lone backslash
   function automatic void gen_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: put_byte(rxp_pkg::CH_OPEN);
            1: put_byte(rxp_pkg::CH_CLOSE);
            2: put_byte(rxp_pkg::CH_BSLASH);
            3: put_byte(rxp_pkg::CH_UNION);
            4: put_byte(cur_concat);
            5: put_byte($urandom_range(0, 1) ? rxp_pkg::CH_STAR : rxp_pkg::CH_PLUS);
            default: put_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // nesting near or past the stack depth so pushes can get dropped
   function automatic void gen_deep();
      int n;
      n = $urandom_range(OP_DEPTH - 2, OP_DEPTH + 6);
      for (int i = 0; i < n; i++) put_byte(rxp_pkg::CH_OPEN);
      put_byte(plain_byte());
      put_byte(rxp_pkg::CH_STAR);
      put_byte(cur_concat);
      put_byte(plain_byte());
      n = $urandom_range(0, n);
      for (int i = 0; i < n; i++) put_byte(rxp_pkg::CH_CLOSE);
   endfunction

   // one input item; valid is held until accepted
   task automatic send_item(input logic [7:0] c, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_item(c, last);
   endtask

   // sends byte_q as one expression, last flag on its final byte
   task automatic send_text(output int count);
      count = byte_q.size();
      for (int i = 0; i < count; i++)
         send_item(byte_q[i], i == count - 1);
      byte_q = {};
   endtask

   task automatic send_str(input string s);
      int n;
      byte_q = {};
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
      send_text(n);
   endtask

   // let the block drain before touching the register
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (PAUSE_CYCLES) @(posedge clock);
   endtask

   task automatic write_concat(input logic [7:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_concat = v;
      sb.concat  = v;
   endtask

   initial begin
      logic [7:0] cfg_vals [NUM_PHASES];
      int         sent;
      int         n;
      cfg_vals = '{8'd0, 8'd255, rxp_pkg::CH_PLUS, rxp_pkg::CH_UNION,
                   rxp_pkg::CH_BSLASH, rxp_pkg::CH_OPEN, rxp_pkg::CONCAT_RESET, 8'd0};
      cfg_vals[NUM_PHASES - 1] = 8'($urandom_range(0, 255));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed expressions under the reset concat character
      send_str("a.b");
      send_str("(a|b)*.c");
      send_str("a+|\\*");
      send_str(")");            // unmatched close alone: bare end marker
      send_str("\\");           // trailing lone backslash: bare end marker
      send_str("(a");           // unmatched open comes out at the flush
      send_str("a|b*");
      send_str("a.b)|c");       // unmatched close mid-expression
      byte_q = {8'h00, rxp_pkg::CONCAT_RESET, 8'hFF};
      send_text(n);
      settle();

      // random phases, each under its own concat character
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_concat(cfg_vals[ph]);
         idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         sent = 0;
         if (ph == 2 || ph == 5) begin
            gen_deep();
            send_text(n);
            sent += n;
         end
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               7, 8: gen_noise();
               9: begin
                  if ($urandom_range(0, 3) == 0) gen_deep();
                  else gen_alt(2);
               end
               default: gen_alt(2);
            endcase
            send_text(n);
            sent += n;
         end
         settle();
      end

      if (sb.errors == 0) begin
         $display("tb_regex_infix_to_postfix: done, clean");
      end else begin
         $display("tb_regex_infix_to_postfix: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

### regex_infix_to_postfix.f
hw/rtl/rxp_pkg.sv
hw/rtl/rxp_ram.sv
hw/rtl/regex_infix_to_postfix.sv
sim/tb_regex_infix_to_postfix.sv
